### hdl/ftpd_pkg.sv
package ftpd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CH_IDX_W = 3;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned NUM_W = 7;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_ZC   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_PULSE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_LEVEL  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] GATE_PULSE_RST = 10'd320;
  localparam logic [CFG_DATA_W-1:0] TICKS_LEVEL_RST = 10'd200;

  localparam logic [7:0] START_MARK = 8'h25;
  localparam logic [7:0] END_MARK   = 8'h40;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [NUM_W-1:0] MAX_LEVEL = 7'd99;

  typedef struct packed {
    logic                relay1;
    logic                relay2;
    logic                st_bit;
    logic                dim_hit;
    logic [CH_IDX_W-1:0] dim_ch;
    logic                st_on;
    logic                st_off;
    logic [DELAY_W-1:0]  delay;
  } ftpd_cmd_t;

  typedef struct packed {
    logic ovr;
    logic start;
    logic frame;
    logic ok;
  } ftpd_flags_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [NUM_W-1:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    logic [NUM_W-1:0] h;
    logic [NUM_W-1:0] l;
    h = NUM_W'(hi[3:0]);
    l = NUM_W'(lo[3:0]);
    if (!is_digit(hi)) begin
      return '0;
    end else if (!is_digit(lo)) begin
      return h;
    end else begin
      return NUM_W'(h * NUM_W'(10)) + l;
    end
  endfunction

endpackage

### hdl/ftpd_frame.sv
module ftpd_frame #(
  parameter int unsigned FRAME_BYTES = 16,
  parameter int unsigned DIMMER_CHANNELS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                byte_en,
  input  logic [7:0]                          rx_byte,
  input  logic                                rx_overrun,
  input  logic [ftpd_pkg::CFG_DATA_W-1:0]     ticks_per_level,
  output ftpd_pkg::ftpd_cmd_t                 cmd,
  output ftpd_pkg::ftpd_flags_t               flags
);
  import ftpd_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam int unsigned PROD_W = NUM_W + CFG_DATA_W;

  logic [7:0]       bytes_r [FRAME_BYTES];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             at_start;
  logic             at_last;
  logic             hdr_ok;
  logic             frame_ok;
  logic [NUM_W-1:0] sw;
  logic [NUM_W-1:0] level;
  logic [NUM_W-1:0] lvl_inv;
  logic [PROD_W-1:0] prod;
  logic [7:0]       st;

  assign at_start = (pos_r == '0);
  assign at_last  = (pos_r == POS_W'(FRAME_BYTES - 1));
  assign hdr_ok   = (bytes_r[1] == START_MARK) && (bytes_r[FRAME_BYTES-2] == END_MARK) &&
                    (rx_byte == END_MARK);
  assign frame_ok = byte_en && at_last && hdr_ok;

  always_comb begin
    pos_nxt = pos_r;
    if (byte_en) begin
      if (at_start) begin
        pos_nxt = (rx_byte == START_MARK) ? POS_W'(1) : '0;
      end else if (at_last) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      bytes_r[pos_r] <= rx_byte;
    end
  end

  assign flags.ovr   = byte_en && rx_overrun;
  assign flags.start = byte_en && at_start && (rx_byte != START_MARK);
  assign flags.frame = byte_en && at_last && !hdr_ok;
  assign flags.ok    = frame_ok;

  assign sw      = two_digits(bytes_r[2], bytes_r[3]);
  assign st      = bytes_r[4];
  assign level   = two_digits(bytes_r[5], bytes_r[6]);
  assign lvl_inv = MAX_LEVEL - level;
  assign prod    = PROD_W'(lvl_inv) * PROD_W'(ticks_per_level);

  always_comb begin
    cmd.relay1  = frame_ok && (sw == NUM_W'(1));
    cmd.relay2  = frame_ok && (sw == NUM_W'(2));
    cmd.st_bit  = st[0];
    cmd.dim_hit = frame_ok && (sw >= NUM_W'(3)) && (sw < NUM_W'(3 + DIMMER_CHANNELS));
    cmd.dim_ch  = CH_IDX_W'(sw - NUM_W'(3));
    cmd.st_on   = (st == CHAR_ONE);
    cmd.st_off  = (st == CHAR_ZERO);
    cmd.delay   = (prod > PROD_W'(2**DELAY_W - 1)) ? {DELAY_W{1'b1}} : prod[DELAY_W-1:0];
  end

endmodule

### hdl/ftpd_chan.sv
module ftpd_chan #(
  parameter int unsigned CH = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tick,
  input  logic                            zc,
  input  ftpd_pkg::ftpd_cmd_t             cmd,
  input  logic [ftpd_pkg::CFG_DATA_W-1:0] gate_pulse_ticks,
  output logic                            gate_nxt
);
  import ftpd_pkg::*;

  logic                  gate_r;
  logic                  armed_r, armed_nxt;
  logic [DELAY_W-1:0]    dlen_r, dlen_nxt;
  logic [DELAY_W-1:0]    dcnt_r, dcnt_nxt;
  logic                  drun_r, drun_nxt;
  logic [CFG_DATA_W-1:0] pcnt_r, pcnt_nxt;
  logic                  prun_r, prun_nxt;

  always_comb begin
    gate_nxt  = gate_r;
    armed_nxt = armed_r;
    dlen_nxt  = dlen_r;
    dcnt_nxt  = dcnt_r;
    drun_nxt  = drun_r;
    pcnt_nxt  = pcnt_r;
    prun_nxt  = prun_r;
    if (tick) begin
      if (prun_r) begin
        if (pcnt_r <= CFG_DATA_W'(1)) begin
          pcnt_nxt = '0;
          prun_nxt = 1'b0;
          gate_nxt = 1'b1;
        end else begin
          pcnt_nxt = pcnt_r - CFG_DATA_W'(1);
        end
      end
      if (drun_r) begin
        if (dcnt_r == '0) begin
          drun_nxt = 1'b0;
          gate_nxt = 1'b0;
          pcnt_nxt = gate_pulse_ticks;
          prun_nxt = 1'b1;
        end else begin
          dcnt_nxt = dcnt_r - DELAY_W'(1);
        end
      end
    end
    if (zc && armed_r) begin
      dcnt_nxt = dlen_r;
      drun_nxt = 1'b1;
    end
    if (cmd.dim_hit && (cmd.dim_ch == CH_IDX_W'(CH))) begin
      if (cmd.st_on) begin
        dlen_nxt  = cmd.delay;
        armed_nxt = 1'b1;
      end else begin
        armed_nxt = 1'b0;
        if (cmd.st_off) begin
          gate_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= 1'b1;
      armed_r <= 1'b0;
      dlen_r  <= '0;
      dcnt_r  <= '0;
      drun_r  <= 1'b0;
      pcnt_r  <= '0;
      prun_r  <= 1'b0;
    end else begin
      gate_r  <= gate_nxt;
      armed_r <= armed_nxt;
      dlen_r  <= dlen_nxt;
      dcnt_r  <= dcnt_nxt;
      drun_r  <= drun_nxt;
      pcnt_r  <= pcnt_nxt;
      prun_r  <= prun_nxt;
    end
  end

endmodule

### hdl/framed_triac_phase_dimmer.sv
// Framed triac phase-angle dimmer with two relays. Each input transaction is one
// event (mode 0 timer tick, 1 received byte, 2 zero-cross) and yields exactly one
// output transaction with the relay levels, the gate levels (1 idle, 0 fire) and
// the receive flags. All work for an event is done combinationally ahead of the result
// register, so one transaction is taken every clock as long as the result is drained.
// A frame of FRAME_BYTES bytes must open with "%%" and close with "@@"; it then names
// a switch (two digits), a state and a two-digit level. Switches 1, 2 set the relays;
// switches 3 to DIMMER_CHANNELS + 2 arm a dimmer with delay (99 - level) *
// ticks_per_level ticks, saturated at 65535. Write the registers only while the block is idle.
module framed_triac_phase_dimmer #(
  parameter int unsigned DIMMER_CHANNELS = 3,
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_rx_overrun,
  input  logic [DIMMER_CHANNELS-1:0]      in_zc_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_relay_one,
  output logic                            out_relay_two,
  output logic [DIMMER_CHANNELS-1:0]      out_gate_levels,
  output logic                            out_overrun_error,
  output logic                            out_start_error,
  output logic                            out_frame_error,
  output logic                            out_frame_accepted,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftpd_pkg::*;

  logic                       acc;
  logic                       tick;
  logic                       byte_en;
  logic                       zc_en;
  logic [CFG_DATA_W-1:0]      gate_pulse_r;
  logic [CFG_DATA_W-1:0]      ticks_level_r;
  logic [1:0]                 relay_r, relay_nxt;
  logic [DIMMER_CHANNELS-1:0] gate_nxt;
  logic                       out_valid_r;
  ftpd_cmd_t                  cmd;
  ftpd_flags_t                flags;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign tick      = acc && (in_mode == MODE_TICK);
  assign byte_en   = acc && (in_mode == MODE_BYTE);
  assign zc_en     = acc && (in_mode == MODE_ZC);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_pulse_r  <= GATE_PULSE_RST;
      ticks_level_r <= TICKS_LEVEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GATE_PULSE_TICKS: gate_pulse_r  <= cfg_data;
        CFG_TICKS_PER_LEVEL:  ticks_level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ftpd_frame #(
    .FRAME_BYTES    (FRAME_BYTES),
    .DIMMER_CHANNELS(DIMMER_CHANNELS)
  ) u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (byte_en),
    .rx_byte        (in_rx_byte),
    .rx_overrun     (in_rx_overrun),
    .ticks_per_level(ticks_level_r),
    .cmd            (cmd),
    .flags          (flags)
  );

  for (genvar i = 0; i < DIMMER_CHANNELS; i++) begin : g_chan
    ftpd_chan #(
      .CH(i)
    ) u_chan (
      .clk             (clk),
      .rst_n           (rst_n),
      .tick            (tick),
      .zc              (zc_en && in_zc_mask[i]),
      .cmd             (cmd),
      .gate_pulse_ticks(gate_pulse_r),
      .gate_nxt        (gate_nxt[i])
    );
  end

  always_comb begin
    relay_nxt = relay_r;
    if (cmd.relay1) begin
      relay_nxt[0] = cmd.st_bit;
    end
    if (cmd.relay2) begin
      relay_nxt[1] = cmd.st_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      relay_r <= relay_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_relay_one      <= relay_nxt[0];
      out_relay_two      <= relay_nxt[1];
      out_gate_levels    <= gate_nxt;
      out_overrun_error  <= flags.ovr;
      out_start_error    <= flags.start;
      out_frame_error    <= flags.frame;
      out_frame_accepted <= flags.ok;
    end
  end

endmodule
